>>> rtl/gcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcg_pkg
// Shared widths, register indexes, reset values, chip codes and sequencer
// types of the Gold code generator.
// ----------------------------------------------------------------------------
package gcg_pkg;

    localparam int MAX_SEQUENCE_LENGTH_DEF = 1023;
    localparam int MAX_LFSR_BITS_DEF       = 10;

    localparam int LEN_W   = 10;   // sequence length, chip position, taps
    localparam int BITS_W  = 4;    // lfsr_length register
    localparam int CNT_W   = 11;   // code count, code number
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 11;
    localparam int CHIP_W  = 2;

    localparam logic [CFG_A_W-1:0] REG_LFSR_LENGTH     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_TAPS_FIRST      = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_TAPS_SECOND     = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_SEQUENCE_LENGTH = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_CODE_COUNT      = 3'd4;

    localparam logic [BITS_W-1:0] RST_LFSR_LENGTH     = 4'd5;
    localparam logic [LEN_W-1:0]  RST_TAPS_FIRST      = 10'd18;
    localparam logic [LEN_W-1:0]  RST_TAPS_SECOND     = 10'd30;
    localparam logic [LEN_W-1:0]  RST_SEQUENCE_LENGTH = 10'd31;
    localparam logic [CNT_W-1:0]  RST_CODE_COUNT      = 11'd1;

    localparam logic signed [CHIP_W-1:0] CHIP_NEG  = -2'sd1;
    localparam logic signed [CHIP_W-1:0] CHIP_POS  = 2'sd1;
    localparam logic signed [CHIP_W-1:0] CHIP_NONE = 2'sd0;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_FILL,
        ST_SEARCH,
        ST_WALK,
        ST_DRAIN,
        ST_TEST,
        ST_FETCH,
        ST_EMIT
    } gcg_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_EMIT,
        PH_DONE,
        PH_FAILED
    } gcg_phase_t;

endpackage

>>> rtl/gold_code_generator.sv
`timescale 1ns / 1ps
// A plain request passes ST_FETCH and ST_EMIT before its result is registered;
// idle, done or failed requests are answered straight from ST_WAIT. A search
// runs ST_SEARCH, ST_WALK over n bits (n the sequence length), ST_DRAIN and
// ST_TEST per candidate tried; a restart first fills n entries of both LFSR
// sequences in ST_FILL. One request at a time; the walks through the memories set the pace.
// Reset: asynchronous, active low; config returns to its defaults, no code held.
// ----------------------------------------------------------------------------
// gold_code_generator
// Fills two LFSR sequences, searches balanced Gold code candidates one bit a
// cycle, and hands out one chip of the kept codes per request (none when idle, done or failed).
// ----------------------------------------------------------------------------
module gold_code_generator #(
    parameter int MAX_SEQUENCE_LENGTH = gcg_pkg::MAX_SEQUENCE_LENGTH_DEF,
    parameter int MAX_LFSR_BITS       = gcg_pkg::MAX_LFSR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gcg_pkg::CFG_A_W-1:0]        cfg_addr,
    input  logic [gcg_pkg::CFG_D_W-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gcg_pkg::CHIP_W-1:0]  chip,
    output logic [gcg_pkg::CNT_W-1:0]          code_number,
    output logic [gcg_pkg::LEN_W-1:0]          chip_number,
    output logic                               last,
    output logic                               failed
);
    import gcg_pkg::*;

    localparam int DEPTH  = (MAX_SEQUENCE_LENGTH < 1023) ? MAX_SEQUENCE_LENGTH : 1023;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LFSR_W = (MAX_LFSR_BITS > LEN_W) ? MAX_LFSR_BITS : LEN_W;

    // configuration
    logic [BITS_W-1:0] lfsr_len_reg;
    logic [LEN_W-1:0]  taps_a_reg, taps_b_reg, seq_len_reg;
    logic [CNT_W-1:0]  code_cnt_reg;

    // sequencer
    gcg_state_t        state_reg, state_next;
    gcg_phase_t        phase_reg, phase_next;
    logic [LEN_W-1:0]  run_len_reg, run_len_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [LFSR_W-1:0] lfsr_a_reg, lfsr_a_next, lfsr_b_reg, lfsr_b_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  rot_reg, rot_next;
    logic [CNT_W-1:0]  cand_reg, cand_next;
    logic [LEN_W-1:0]  tally_reg, tally_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              wv_reg, wv_next;
    logic [ADDR_W-1:0] wd_idx_reg;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic signed [CHIP_W-1:0] chip_reg, chip_next;
    logic [CNT_W-1:0]         code_num_reg, code_num_next;
    logic [LEN_W-1:0]         chip_num_reg, chip_num_next;
    logic                     last_reg, last_next;
    logic                     failed_reg, failed_next;

    // sequence and candidate stores
    logic first_mem  [DEPTH];
    logic second_mem [DEPTH];
    logic cand_mem   [DEPTH];
    logic f_q_reg, s_q_reg, c_q_reg;
    logic fill_we;
    logic cand_bit;

    logic              in_xfer;
    logic [4:0]        bits_clamp;
    logic [LFSR_W-1:0] seed;
    logic [LEN_W-1:0]  len_clamp;
    logic [CNT_W-1:0]  n_ext;
    logic              balanced;

    assign in_ready    = (state_reg == ST_WAIT) && (!out_valid_reg || out_ready);
    assign in_xfer     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign chip        = chip_reg;
    assign code_number = code_num_reg;
    assign chip_number = chip_num_reg;
    assign last        = last_reg;
    assign failed      = failed_reg;

    assign n_ext = {1'b0, run_len_reg};

    always_comb
    begin
        if (lfsr_len_reg == '0)
            bits_clamp = 5'd1;
        else if ({1'b0, lfsr_len_reg} > 5'(MAX_LFSR_BITS))
            bits_clamp = 5'(MAX_LFSR_BITS);
        else
            bits_clamp = {1'b0, lfsr_len_reg};
        seed = LFSR_W'(1) << (bits_clamp - 5'd1);

        if (seq_len_reg == '0)
            len_clamp = LEN_W'(1);
        else if (seq_len_reg > LEN_W'(DEPTH))
            len_clamp = LEN_W'(DEPTH);
        else
            len_clamp = seq_len_reg;
    end

    // first sequence alone, second alone, or first against rotated second
    always_comb
    begin
        if (cand_reg == CNT_W'(0))
            cand_bit = f_q_reg;
        else if (cand_reg == CNT_W'(1))
            cand_bit = s_q_reg;
        else
            cand_bit = f_q_reg ^ s_q_reg;
    end

    assign balanced = ({tally_reg, 1'b0} == n_ext + CNT_W'(1))
                   || ({tally_reg, 1'b0} + CNT_W'(1) == n_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_len_reg <= RST_LFSR_LENGTH;
            taps_a_reg   <= RST_TAPS_FIRST;
            taps_b_reg   <= RST_TAPS_SECOND;
            seq_len_reg  <= RST_SEQUENCE_LENGTH;
            code_cnt_reg <= RST_CODE_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LFSR_LENGTH:     lfsr_len_reg <= cfg_wdata[BITS_W-1:0];
                REG_TAPS_FIRST:      taps_a_reg   <= cfg_wdata[LEN_W-1:0];
                REG_TAPS_SECOND:     taps_b_reg   <= cfg_wdata[LEN_W-1:0];
                REG_SEQUENCE_LENGTH: seq_len_reg  <= cfg_wdata[LEN_W-1:0];
                REG_CODE_COUNT:      code_cnt_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        run_len_next   = run_len_reg;
        run_cnt_next   = run_cnt_reg;
        lfsr_a_next    = lfsr_a_reg;
        lfsr_b_next    = lfsr_b_reg;
        idx_next       = idx_reg;
        rot_next       = rot_reg;
        cand_next      = cand_reg;
        tally_next     = tally_reg;
        kept_next      = kept_reg;
        pos_next       = pos_reg;
        wv_next        = 1'b0;
        fill_we        = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        chip_next      = chip_reg;
        code_num_next  = code_num_reg;
        chip_num_next  = chip_num_reg;
        last_next      = last_reg;
        failed_next    = failed_reg;

        if (wv_reg)
            tally_next = tally_reg + LEN_W'(cand_bit);

        unique case (state_reg)
            ST_WAIT:
            begin
                if (in_xfer)
                begin
                    if (restart)
                    begin
                        run_len_next = len_clamp;
                        run_cnt_next = (code_cnt_reg == '0) ? CNT_W'(1) : code_cnt_reg;
                        lfsr_a_next  = seed;
                        lfsr_b_next  = seed;
                        idx_next     = '0;
                        cand_next    = '0;
                        kept_next    = '0;
                        pos_next     = '0;
                        phase_next   = PH_SEARCH;
                        state_next   = ST_FILL;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_SEARCH: state_next = ST_SEARCH;
                            PH_EMIT:   state_next = ST_FETCH;
                            default:
                            begin
                                out_valid_next = 1'b1;
                                chip_next      = CHIP_NONE;
                                code_num_next  = '0;
                                chip_num_next  = '0;
                                last_next      = 1'b0;
                                failed_next    = (phase_reg == PH_FAILED);
                            end
                        endcase
                    end
                end
            end

            ST_FILL:
            begin
                fill_we     = 1'b1;
                lfsr_a_next = lfsr_a_reg[0] ? ((lfsr_a_reg >> 1) ^ LFSR_W'(taps_a_reg))
                                            : (lfsr_a_reg >> 1);
                lfsr_b_next = lfsr_b_reg[0] ? ((lfsr_b_reg >> 1) ^ LFSR_W'(taps_b_reg))
                                            : (lfsr_b_reg >> 1);
                idx_next    = idx_reg + LEN_W'(1);
                if (idx_reg + LEN_W'(1) == run_len_reg)
                    state_next = ST_SEARCH;
            end

            ST_SEARCH:
            begin
                if (cand_reg > n_ext)
                begin
                    // candidates exhausted
                    out_valid_next = 1'b1;
                    chip_next      = CHIP_NONE;
                    code_num_next  = '0;
                    chip_num_next  = '0;
                    last_next      = 1'b0;
                    failed_next    = 1'b1;
                    phase_next     = PH_FAILED;
                    state_next     = ST_WAIT;
                end
                else
                begin
                    idx_next   = '0;
                    rot_next   = (cand_reg >= CNT_W'(2)) ? LEN_W'(cand_reg - CNT_W'(2)) : '0;
                    tally_next = '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                wv_next  = 1'b1;
                idx_next = idx_reg + LEN_W'(1);
                rot_next = (rot_reg + LEN_W'(1) == run_len_reg) ? '0 : rot_reg + LEN_W'(1);
                if (idx_reg + LEN_W'(1) == run_len_reg)
                    state_next = ST_DRAIN;
            end

            ST_DRAIN:
                state_next = ST_TEST;

            ST_TEST:
            begin
                cand_next = cand_reg + CNT_W'(1);
                if (balanced)
                begin
                    kept_next  = kept_reg + CNT_W'(1);
                    pos_next   = '0;
                    phase_next = PH_EMIT;
                    state_next = ST_FETCH;
                end
                else
                    state_next = ST_SEARCH;
            end

            ST_FETCH:
                state_next = ST_EMIT;

            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                chip_next      = c_q_reg ? CHIP_NEG : CHIP_POS;
                code_num_next  = kept_reg - CNT_W'(1);
                chip_num_next  = pos_reg;
                failed_next    = 1'b0;
                last_next      = 1'b0;
                if (pos_reg + LEN_W'(1) == run_len_reg)
                begin
                    pos_next = '0;
                    if (kept_reg >= run_cnt_reg)
                    begin
                        last_next  = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_SEARCH;
                end
                else
                    pos_next = pos_reg + LEN_W'(1);
                state_next = ST_WAIT;
            end

            default:
                state_next = ST_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            phase_reg     <= PH_IDLE;
            run_len_reg   <= '0;
            run_cnt_reg   <= '0;
            idx_reg       <= '0;
            rot_reg       <= '0;
            cand_reg      <= '0;
            tally_reg     <= '0;
            kept_reg      <= '0;
            pos_reg       <= '0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            run_len_reg   <= run_len_next;
            run_cnt_reg   <= run_cnt_next;
            idx_reg       <= idx_next;
            rot_reg       <= rot_next;
            cand_reg      <= cand_next;
            tally_reg     <= tally_next;
            kept_reg      <= kept_next;
            pos_reg       <= pos_next;
            wv_reg        <= wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lfsr_a_reg   <= lfsr_a_next;
        lfsr_b_reg   <= lfsr_b_next;
        wd_idx_reg   <= idx_reg[ADDR_W-1:0];
        chip_reg     <= chip_next;
        code_num_reg <= code_num_next;
        chip_num_reg <= chip_num_next;
        last_reg     <= last_next;
        failed_reg   <= failed_next;
    end

    // one write and one registered read per store each cycle
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            first_mem[idx_reg[ADDR_W-1:0]]  <= lfsr_a_reg[0];
            second_mem[idx_reg[ADDR_W-1:0]] <= lfsr_b_reg[0];
        end
        if (wv_reg)
            cand_mem[wd_idx_reg] <= cand_bit;
        f_q_reg <= first_mem[idx_reg[ADDR_W-1:0]];
        s_q_reg <= second_mem[rot_reg[ADDR_W-1:0]];
        c_q_reg <= cand_mem[pos_reg[ADDR_W-1:0]];
    end

`ifndef SYNTHESIS
    a_fail_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(failed && last))
        else $error("failure result flagged as last chip");

    a_fail_no_chip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failed |-> chip == CHIP_NONE)
        else $error("failure result carries a chip");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("request taken while result register still full");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> idx_reg < run_len_reg && rot_reg < run_len_reg)
        else $error("candidate walk index out of range");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gold code generator testbench
// Drives chip requests and register writes into gold_code_generator, models
// the LFSR fill, balanced code search and chip hand-out on the side, and
// checks every chip transfer against the modeled value in order.
// ----------------------------------------------------------------------------
module tb_top;

    import gcg_pkg::*;

    localparam int SEQ_DEPTH   = MAX_SEQUENCE_LENGTH_DEF;
    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_GAP     = 12;

    typedef struct packed {
        logic signed [CHIP_W-1:0] chip;
        logic [CNT_W-1:0]         code_number;
        logic [LEN_W-1:0]         chip_number;
        logic                     last;
        logic                     failed;
    } chip_entry_t;

    // Tracks the generator state and the chips still owed by the block.
    class chip_ledger;
        logic [BITS_W-1:0] width_reg;
        logic [LEN_W-1:0]  taps_a_reg;
        logic [LEN_W-1:0]  taps_b_reg;
        logic [LEN_W-1:0]  length_reg;
        logic [CNT_W-1:0]  count_reg;

        bit         seq_a[SEQ_DEPTH];
        bit         seq_b[SEQ_DEPTH];
        bit         cand[SEQ_DEPTH];
        int         run_len;
        int         run_want;
        int         next_cand;
        int         shift;
        int         chip_pos;
        int         kept;
        gcg_phase_t phase;

        chip_entry_t chips_owed[$];
        int          fault_count;

        function new();
            width_reg   = RST_LFSR_LENGTH;
            taps_a_reg  = RST_TAPS_FIRST;
            taps_b_reg  = RST_TAPS_SECOND;
            length_reg  = RST_SEQUENCE_LENGTH;
            count_reg   = RST_CODE_COUNT;
            run_len     = 0;
            run_want    = 0;
            next_cand   = 0;
            shift       = 0;
            chip_pos    = 0;
            kept        = 0;
            phase       = PH_IDLE;
            fault_count = 0;
        endfunction

        function void write_register(logic [CFG_A_W-1:0] idx, int unsigned value);
            case (idx)
                REG_LFSR_LENGTH:     width_reg  = value[BITS_W-1:0];
                REG_TAPS_FIRST:      taps_a_reg = value[LEN_W-1:0];
                REG_TAPS_SECOND:     taps_b_reg = value[LEN_W-1:0];
                REG_SEQUENCE_LENGTH: length_reg = value[LEN_W-1:0];
                REG_CODE_COUNT:      count_reg  = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void start_generation();
            int lfsr_bits;
            logic [LEN_W-1:0] reg_a;
            logic [LEN_W-1:0] reg_b;
            lfsr_bits = width_reg;
            if (lfsr_bits < 1) lfsr_bits = 1;
            if (lfsr_bits > MAX_LFSR_BITS_DEF) lfsr_bits = MAX_LFSR_BITS_DEF;
            run_len = length_reg;
            if (run_len < 1) run_len = 1;
            if (run_len > SEQ_DEPTH) run_len = SEQ_DEPTH;
            run_want = (count_reg == '0) ? 1 : int'(count_reg);
            reg_a = LEN_W'(1 << (lfsr_bits - 1));
            reg_b = reg_a;
            for (int i = 0; i < run_len; i++) begin
                seq_a[i] = reg_a[0];
                seq_b[i] = reg_b[0];
                reg_a = reg_a[0] ? ((reg_a >> 1) ^ taps_a_reg) : (reg_a >> 1);
                reg_b = reg_b[0] ? ((reg_b >> 1) ^ taps_b_reg) : (reg_b >> 1);
            end
            next_cand = 0;
            shift     = 0;
            chip_pos  = 0;
            kept      = 0;
            phase     = PH_SEARCH;
        endfunction

        // Candidate 0 and 1 are the plain sequences, the rest XOR a rotation.
        function bit build_candidate(int c);
            int ones;
            int k;
            bit b;
            ones = 0;
            for (int j = 0; j < run_len; j++) begin
                if (c == 0) begin
                    b = seq_a[j];
                end else if (c == 1) begin
                    b = seq_b[j];
                end else begin
                    k = shift + j;
                    if (k >= run_len) k -= run_len;
                    b = seq_a[j] ^ seq_b[k];
                end
                cand[j] = b;
                ones += b;
            end
            return (2 * ones == run_len + 1) || (2 * ones + 1 == run_len);
        endfunction

        function bit seek_balanced_code();
            int c;
            while (next_cand <= run_len) begin
                c = next_cand;
                if (c >= 2) begin
                    if (c - 2 >= run_len - 1) break;
                    shift = c - 2;
                end
                next_cand = c + 1;
                if (build_candidate(c)) return 1'b1;
            end
            next_cand = run_len + 1;
            return 1'b0;
        endfunction

        function void log_request(bit restart_req);
            chip_entry_t r;
            int p;
            r = '0;
            if (restart_req) start_generation();
            if (phase == PH_SEARCH) begin
                if (seek_balanced_code()) begin
                    kept++;
                    chip_pos = 0;
                    phase = PH_EMIT;
                end else begin
                    phase = PH_FAILED;
                end
            end
            if (phase == PH_EMIT) begin
                p = chip_pos;
                if (p >= run_len) p = 0;
                r.chip        = cand[p] ? CHIP_NEG : CHIP_POS;
                r.code_number = CNT_W'(kept - 1);
                r.chip_number = LEN_W'(p);
                p++;
                if (p >= run_len) begin
                    chip_pos = 0;
                    if (kept >= run_want) begin
                        r.last = 1'b1;
                        phase = PH_DONE;
                    end else begin
                        phase = PH_SEARCH;
                    end
                end else begin
                    chip_pos = p;
                end
            end else if (phase == PH_FAILED) begin
                r.failed = 1'b1;
            end
            chips_owed.push_back(r);
        endfunction

        function void match_chip(chip_entry_t got);
            chip_entry_t want;
            if (chips_owed.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("stray chip: chip %0d code %0d pos %0d last %0b failed %0b",
                             got.chip, got.code_number, got.chip_number, got.last,
                             got.failed);
                return;
            end
            want = chips_owed.pop_front();
            if (got.chip !== want.chip || got.code_number !== want.code_number ||
                got.chip_number !== want.chip_number || got.last !== want.last ||
                got.failed !== want.failed) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("chip mismatch: want %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                             want.chip, want.code_number, want.chip_number, want.last,
                             want.failed, got.chip, got.code_number, got.chip_number,
                             got.last, got.failed);
            end
        endfunction

        function int owed();
            return chips_owed.size();
        endfunction

        function int failures();
            return fault_count + chips_owed.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_A_W-1:0]         cfg_addr;
    logic [CFG_D_W-1:0]         cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic                       restart;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [CHIP_W-1:0]   chip;
    logic [CNT_W-1:0]           code_number;
    logic [LEN_W-1:0]           chip_number;
    logic                       last;
    logic                       failed;

    chip_ledger ledger;
    int         requests_sent;
    int         cycle_count;
    int         rx_hold;
    bit         tx_quiet;
    bit         rx_quiet;

    gold_code_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chip        (chip),
        .code_number (code_number),
        .chip_number (chip_number),
        .last        (last),
        .failed      (failed)
    );

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check each transfer, then hold ready low for a drawn stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            ledger.match_chip('{chip: chip, code_number: code_number,
                                chip_number: chip_number, last: last, failed: failed});
            rx_hold = draw_gap(rx_quiet);
            if (rx_hold > 0) out_ready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            if (rx_hold == 0) out_ready <= 1'b1;
        end
    end

    // Maximal-length tap masks for the right-shifting Galois form.
    function automatic int unsigned primitive_taps(int lfsr_bits);
        case (lfsr_bits)
            2:       return 10'h003;
            3:       return 10'h006;
            4:       return 10'h00C;
            5:       return 10'h014;
            6:       return 10'h030;
            7:       return 10'h060;
            8:       return 10'h0B8;
            9:       return 10'h110;
            default: return 10'h240;
        endcase
    endfunction

    // Valid stays up into the next request unless a gap is drawn.
    task automatic issue_chip_request(input bit restart_req);
        int gap;
        in_valid <= 1'b1;
        restart  <= restart_req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ledger.log_request(restart_req);
        requests_sent++;
        gap = draw_gap(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_chips();
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.owed() != 0);
    endtask

    task automatic load_generator_config(input int unsigned lfsr_bits,
                                         input int unsigned taps_a,
                                         input int unsigned taps_b,
                                         input int unsigned length,
                                         input int unsigned count);
        logic [CFG_A_W-1:0] idx[5];
        int unsigned        vals[5];
        idx  = '{REG_LFSR_LENGTH, REG_TAPS_FIRST, REG_TAPS_SECOND,
                 REG_SEQUENCE_LENGTH, REG_CODE_COUNT};
        vals = '{lfsr_bits, taps_a, taps_b, length, count};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= CFG_D_W'(vals[i]);
            @(posedge clk);
            ledger.write_register(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned lfsr_bits;
        int unsigned taps_a;
        int unsigned taps_b;
        int unsigned length;
        int unsigned count;
        int          burst;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        restart     = 1'b0;
        out_ready   = 1'b1;
        rx_hold     = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        cycle_count = 0;
        requests_sent = 0;
        ledger = new();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Request before any restart, then a few chips of the reset setting.
        issue_chip_request(1'b0);
        issue_chip_request(1'b1);
        repeat (4) issue_chip_request(1'b0);
        drain_chips();

        // Longest sequence and widest register.
        load_generator_config(10, 10'h240, 10'h204, 1023, 1);
        issue_chip_request(1'b1);
        repeat (2) issue_chip_request(1'b0);
        drain_chips();

        // Zero length, width and count fall back to one; request past the end.
        load_generator_config(0, 0, 1023, 0, 0);
        issue_chip_request(1'b1);
        repeat (2) issue_chip_request(1'b0);
        drain_chips();

        // Candidates run out before the count is met; failure persists.
        load_generator_config(2, 3, 3, 3, 2047);
        issue_chip_request(1'b1);
        repeat (11) issue_chip_request(1'b0);
        drain_chips();

        while (requests_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                lfsr_bits = $urandom_range(2, 6);
                length    = (1 << lfsr_bits) - 1;
                if ($urandom_range(0, 3) == 0) length = $urandom_range(1, 63);
                taps_a = primitive_taps(lfsr_bits);
                case ($urandom_range(0, 2))
                    0:       taps_b = taps_a;
                    1:       taps_b = $urandom_range(0, (1 << lfsr_bits) - 1);
                    default: taps_b = $urandom_range(0, 1023);
                endcase
                count = $urandom_range(0, length + 2);
            end
            else
            begin
                lfsr_bits = $urandom_range(0, 15);
                taps_a    = $urandom_range(0, 1023);
                taps_b    = $urandom_range(0, 1023);
                length    = $urandom_range(0, 40);
                count     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                        : $urandom_range(0, 6);
            end
            load_generator_config(lfsr_bits, taps_a, taps_b, length, count);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(1, 60);
            for (int i = 0; i < burst; i++)
            begin
                if (i > 0 && $urandom_range(0, 24) == 0) drain_chips();
                // Mostly open with a restart; now and then restart mid-code.
                if (i == 0)
                    issue_chip_request($urandom_range(0, 19) != 0);
                else
                    issue_chip_request($urandom_range(0, 32) == 0);
            end
            drain_chips();
        end

        repeat (40) @(posedge clk);
        if (ledger.failures() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
